>>> src/ftam_pkg.sv
// ----------------------------------------------------------------------------
// ftam_pkg
// Shared types and constants of the frame time average and rate meter.
// ----------------------------------------------------------------------------
package ftam_pkg;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned TPS_W     = 32;
  localparam int unsigned AVG_W     = 40;
  localparam int unsigned FPS_W     = 32;
  localparam int unsigned HELD_W    = 7;
  localparam int unsigned ELAPSED_W = 48;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIMESTAMP  = 1'd1;

  localparam logic [TPS_W-1:0]     TPS_RESET   = 32'd10000000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUB,
    S_ADD,
    S_DIV,
    S_TIME,
    S_RATE,
    S_DONE
  } ftam_state_t;

endpackage

>>> src/ftam_in_if.sv
// ----------------------------------------------------------------------------
// ftam_in_if
// Frame event channel: valid/ready handshake with the frame timestamp.
// ----------------------------------------------------------------------------
interface ftam_in_if import ftam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] frame_timestamp;

  modport source (output valid, output frame_timestamp, input ready);
  modport sink   (input valid, input frame_timestamp, output ready);
endinterface

>>> src/ftam_out_if.sv
// ----------------------------------------------------------------------------
// ftam_out_if
// Result channel: valid/ready handshake with average, rate and window status.
// ----------------------------------------------------------------------------
interface ftam_out_if import ftam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AVG_W-1:0]  avg_frame_ticks;
  logic [FPS_W-1:0]  frames_per_second;
  logic [HELD_W-1:0] samples_held;
  logic              delta_accepted;

  modport source (output valid, output avg_frame_ticks, output frames_per_second,
                  output samples_held, output delta_accepted, input ready);
  modport sink   (input valid, input avg_frame_ticks, input frames_per_second,
                  input samples_held, input delta_accepted, output ready);
endinterface

>>> src/frame_time_average_and_rate_meter.sv
// ----------------------------------------------------------------------------
// frame_time_average_and_rate_meter
// Moving average of frame deltas and a frames-per-second counter.
// ----------------------------------------------------------------------------
// Each frame request carries a tick timestamp. The delta to the previous one is
// saturated to DELTA_BITS, kept in a window of the newest WINDOW deltas when it
// lies within one second of the current average, and the average is the
// truncated window sum over the count. Every frame also adds to an elapsed
// tick total; once that passes one second the frame count is published.
// An accepted request passes through S_CHECK, S_SUB, S_ADD, S_DIV, S_TIME and
// S_RATE to S_DONE, where the result is loaded into the output register. The
// sum/count division in S_DIV is a restoring divider that retires one quotient
// bit per cycle of a SUM_W-bit quotient, where SUM_W = DELTA_BITS +
// clog2(WINDOW+1) capped at 64. While the window is still empty and the delta
// is rejected, S_DIV and the division are skipped. The block takes no new
// request while one is in work; a finished result waits in the output register
// while the next request is accepted, and a request stalls at its end only
// while the previous result still waits there.
// The delta window needs no clearing after reset.
// ----------------------------------------------------------------------------
module frame_time_average_and_rate_meter
  import ftam_pkg::*;
#(
  parameter int unsigned WINDOW     = 64,
  parameter int unsigned DELTA_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ftam_in_if.sink              in_frm,
  ftam_out_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = (DELTA_BITS + CNT_W > 64) ? 64 : DELTA_BITS + CNT_W;
  localparam int unsigned ITER_W = $clog2(SUM_W);
  localparam int unsigned ELA_W  = ((DELTA_BITS > ELAPSED_W) ? DELTA_BITS : ELAPSED_W) + 1;

  ftam_state_t state_r, state_nxt;

  logic [TPS_W-1:0]      tps_r;
  logic [TS_W-1:0]       last_r;
  logic [DELTA_BITS-1:0] delta_r;
  logic                  acc_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      count_r;
  logic [SLOT_W-1:0]     oldest_r;
  logic [DELTA_BITS-1:0] avg_r;
  logic [FPS_W-1:0]      frames_r;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [FPS_W-1:0]      rate_r;
  logic [DELTA_BITS-1:0] rd_data_r;
  logic [SUM_W-1:0]      quo_r;
  logic [CNT_W-1:0]      rem_r;
  logic [ITER_W-1:0]     iter_r;

  logic [DELTA_BITS-1:0] win_mem [WINDOW];

  logic                  out_valid_r;
  logic [AVG_W-1:0]      out_avg_r;
  logic [FPS_W-1:0]      out_fps_r;
  logic [HELD_W-1:0]     out_held_r;
  logic                  out_acc_r;

  // combinational datapath
  logic                  in_fire;
  logic                  out_load;
  logic [TS_W-1:0]       raw_delta;
  logic [DELTA_BITS-1:0] sat_delta;
  logic [DELTA_BITS-1:0] diff;
  logic                  accept;
  logic                  full;
  logic [SUM_W-1:0]      sum_add;
  logic [CNT_W:0]        div_shift;
  logic                  div_ge;
  logic [CNT_W-1:0]      rem_nxt;
  logic [SUM_W-1:0]      quo_nxt;
  logic [ELA_W-1:0]      elapsed_add;
  logic [SLOT_W-1:0]     wr_slot;

  assign in_fire   = in_frm.valid && in_frm.ready;
  assign raw_delta = in_frm.frame_timestamp - last_r;
  // backwards or huge jumps clamp to the largest delta
  assign sat_delta = (raw_delta[TS_W-1:DELTA_BITS] != '0) ? {DELTA_BITS{1'b1}}
                                                          : raw_delta[DELTA_BITS-1:0];
  assign diff      = (delta_r >= avg_r) ? (delta_r - avg_r) : (avg_r - delta_r);
  assign accept    = 64'(diff) < 64'(tps_r);
  assign full      = (count_r == CNT_W'(WINDOW));
  assign sum_add   = sum_r + SUM_W'(delta_r);
  assign wr_slot   = full ? oldest_r : SLOT_W'(count_r);

  assign div_shift = {rem_r, quo_r[SUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, count_r};
  assign rem_nxt   = div_ge ? CNT_W'(div_shift - {1'b0, count_r}) : CNT_W'(div_shift);
  assign quo_nxt   = {quo_r[SUM_W-2:0], div_ge};

  assign elapsed_add = ELA_W'(elapsed_r) + ELA_W'(delta_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_SUB;
      S_SUB:   state_nxt = S_ADD;
      S_ADD: begin
        if (acc_r || count_r != '0) state_nxt = S_DIV;
        else                        state_nxt = S_TIME;
      end
      S_DIV:   if (iter_r == '0) state_nxt = S_TIME;
      S_TIME:  state_nxt = S_RATE;
      S_RATE:  state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_res.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_frm.ready = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE:  in_frm.ready = 1'b1;
      S_DONE:  out_load = !out_valid_r || out_res.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and timestamp tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TPS_RESET;
      last_r <= '0;
    end else begin
      if (in_fire) last_r <= in_frm.frame_timestamp;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICKS_PER_SECOND: tps_r  <= cfg_wdata[TPS_W-1:0];
          CFG_START_TIMESTAMP:  last_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) rd_data_r <= win_mem[oldest_r];
    if (state_r == S_ADD && acc_r) win_mem[wr_slot] <= delta_r;
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_fire) delta_r <= sat_delta;
    if (state_r == S_CHECK) acc_r <= accept;
    if (state_r == S_ADD) begin
      quo_r  <= acc_r ? sum_add : sum_r;
      rem_r  <= '0;
      iter_r <= ITER_W'(SUM_W - 1);
    end
    if (state_r == S_DIV) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      iter_r <= iter_r - 1'b1;
    end
  end

  // window, average and rate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      count_r   <= '0;
      oldest_r  <= '0;
      avg_r     <= '0;
      frames_r  <= '0;
      elapsed_r <= '0;
      rate_r    <= '0;
    end else begin
      unique case (state_r)
        S_SUB: begin
          // drop the oldest delta before its slot is overwritten
          if (acc_r && full) sum_r <= sum_r - SUM_W'(rd_data_r);
        end
        S_ADD: begin
          if (acc_r) begin
            sum_r <= sum_add;
            if (full) begin
              oldest_r <= (oldest_r == SLOT_W'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (iter_r == '0) avg_r <= quo_nxt[DELTA_BITS-1:0];
        end
        S_TIME: begin
          frames_r  <= frames_r + 1'b1;
          elapsed_r <= (elapsed_add > ELA_W'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                           : elapsed_add[ELAPSED_W-1:0];
        end
        S_RATE: begin
          if (64'(elapsed_r) > 64'(tps_r)) begin
            rate_r    <= frames_r;
            frames_r  <= '0;
            elapsed_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r  <= AVG_W'(avg_r);
      out_fps_r  <= rate_r;
      out_held_r <= HELD_W'(count_r);
      out_acc_r  <= acc_r;
    end
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.avg_frame_ticks   = out_avg_r;
  assign out_res.frames_per_second = out_fps_r;
  assign out_res.samples_held      = out_held_r;
  assign out_res.delta_accepted    = out_acc_r;

endmodule
